### hw/rtl/sstp_pkg.sv
// ----------------------------------------------------------------------------
// sstp_pkg
// Shared widths, register codes, window type and gradient arithmetic for the
// Sobel structure tensor product pipeline.
// ----------------------------------------------------------------------------
package sstp_pkg;

  localparam int PIX_W         = 8;
  localparam int WIDTH_REG_W   = 12;
  localparam int HEIGHT_REG_W  = 13;
  localparam int ROW_W         = 12;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int GRAD_W        = 11;
  localparam int SCALED_W      = 8;
  localparam int SQ_W          = 14;
  localparam int CROSS_W       = 15;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int MIN_DIM       = 3;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // 3x3 window: rows top to bottom, columns left to right, index row*3+col
  typedef logic [8:0][PIX_W-1:0] window_t;

  // Control from the top level to the line store block
  typedef struct packed {
    logic adv;   // whole pipeline moves one step
    logic load;  // a pixel beat enters at this step
  } win_ctl_t;

  function automatic logic signed [GRAD_W-1:0] pix_ext(input logic [PIX_W-1:0] p);
    pix_ext = signed'({{(GRAD_W-PIX_W){1'b0}}, p});
  endfunction

  // Horizontal Sobel response of the window
  function automatic logic signed [GRAD_W-1:0] grad_x(input window_t w);
    logic signed [GRAD_W-1:0] a, b, c;
    a = pix_ext(w[2]) - pix_ext(w[0]);
    b = pix_ext(w[5]) - pix_ext(w[3]);
    c = pix_ext(w[8]) - pix_ext(w[6]);
    grad_x = a + (b <<< 1) + c;
  endfunction

  // Vertical Sobel response of the window
  function automatic logic signed [GRAD_W-1:0] grad_y(input window_t w);
    logic signed [GRAD_W-1:0] a, b, c;
    a = pix_ext(w[6]) - pix_ext(w[0]);
    b = pix_ext(w[7]) - pix_ext(w[1]);
    c = pix_ext(w[8]) - pix_ext(w[2]);
    grad_y = a + (b <<< 1) + c;
  endfunction

  // Round by (g+4)>>3 with floor, then clip to signed 8 bits
  function automatic logic signed [SCALED_W-1:0] scale_grad(
      input logic signed [GRAD_W-1:0] g);
    logic signed [GRAD_W:0]   t;
    logic signed [GRAD_W-3:0] s;
    t = {g[GRAD_W-1], g} + (GRAD_W+1)'(4);
    s = t[GRAD_W:3];
    if (s > (GRAD_W-2)'(127)) begin
      scale_grad = 8'sd127;
    end else if (s < -(GRAD_W-2)'(128)) begin
      scale_grad = -8'sd128;
    end else begin
      scale_grad = s[SCALED_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/sstp_window.sv
// ----------------------------------------------------------------------------
// sstp_window
// Two line stores in synchronous RAM and the 3x3 pixel window. Each pixel beat
// reads both stores at its column, shifts the window and writes back.
// ----------------------------------------------------------------------------
module sstp_window #(
  parameter int MAX_WIDTH = sstp_pkg::MAX_WIDTH_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sstp_pkg::win_ctl_t       ctl,
  input  logic [sstp_pkg::PIX_W-1:0] pixel,
  input  logic [CW-1:0]            col,
  output sstp_pkg::window_t        win
);

  logic [sstp_pkg::PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [sstp_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [sstp_pkg::PIX_W-1:0] rd_upper, rd_middle;
  logic [sstp_pkg::PIX_W-1:0] fwd_upper, fwd_middle;
  logic [sstp_pkg::PIX_W-1:0] cur_upper, cur_middle;
  logic [sstp_pkg::PIX_W-1:0] s1_px;
  logic [CW-1:0]              s1_col;
  logic                       s1_valid;
  logic                       s1_fwd;
  sstp_pkg::window_t          window;

  // Take the value the previous beat writes when it hits the same column
  assign cur_upper  = s1_fwd ? fwd_upper  : rd_upper;
  assign cur_middle = s1_fwd ? fwd_middle : rd_middle;

  // Read at the new column, write back the beat in stage one
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rd_upper  <= upper_mem[col];
      rd_middle <= middle_mem[col];
      if (s1_valid) begin
        upper_mem[s1_col]  <= cur_middle;
        middle_mem[s1_col] <= s1_px;
      end
    end
  end

  // Stage one payload and forwarding capture
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s1_px      <= pixel;
      s1_col     <= col;
      s1_fwd     <= s1_valid && (s1_col == col);
      fwd_upper  <= cur_middle;
      fwd_middle <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctl.adv) begin
      s1_valid <= ctl.load;
    end
  end

  // Shift the window one column left and insert the new column
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (ctl.adv && s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        window[k*3]   <= window[k*3+1];
        window[k*3+1] <= window[k*3+2];
      end
      window[2] <= cur_upper;
      window[5] <= cur_middle;
      window[8] <= s1_px;
    end
  end

  assign win = window;

endmodule

### hw/rtl/sobel_structure_tensor_products_top.sv
// ----------------------------------------------------------------------------
// sobel_structure_tensor_products_top
// Raster pixel stream in, Sobel gradient products gx*gx, gy*gy, gx*gy out for
// every interior pixel of the frame.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  pixel     pix_valid / pix_stall      pixel, frame_start
//  result    res_valid / res_stall      grad_xx, grad_yy, grad_xy, frame_last
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  One pixel per cycle while pix_stall is low; the line store RAM does one
//  read and one write per beat. The result flag passes s1_res, s2_res and
//  s3_res into the res_valid register. Border pixels produce no beat.
//  Reset (rst, synchronous) clears counters, window and flags; no RAM sweep.
//  pix_stall comes from a registered skid stage: it rises only while a result
//  waits in both the output register and the skid register.
// ----------------------------------------------------------------------------
module sobel_structure_tensor_products_top #(
  parameter int MAX_WIDTH = sstp_pkg::MAX_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pix_valid,
  output logic                                   pix_stall,
  input  logic [sstp_pkg::PIX_W-1:0]             pixel,
  input  logic                                   frame_start,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output logic [sstp_pkg::SQ_W-1:0]              grad_xx,
  output logic [sstp_pkg::SQ_W-1:0]              grad_yy,
  output logic signed [sstp_pkg::CROSS_W-1:0]    grad_xy,
  output logic                                   frame_last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sstp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [sstp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMPW = $clog2(MAX_WIDTH + sstp_pkg::HEIGHT_LIMIT) + 1;
  localparam int HW   = sstp_pkg::HEIGHT_REG_W;

  logic [sstp_pkg::WIDTH_REG_W-1:0]  frame_width;
  logic [sstp_pkg::HEIGHT_REG_W-1:0] frame_height;
  logic [CW-1:0]                     column_count, column_count_next;
  logic [sstp_pkg::ROW_W-1:0]        row_count, row_count_next;

  logic [CMPW-1:0]           w_use, fw_ext, c_ext;
  logic [HW-1:0]             h_use, r_ext;
  logic [CW-1:0]             c_cur;
  logic [sstp_pkg::ROW_W-1:0] r_cur;
  logic                      col_end, row_end, produce, last;
  logic                      accept, adv;

  sstp_pkg::win_ctl_t        win_ctl;
  sstp_pkg::window_t         win;

  logic                      s1_res, s1_last, s2_res, s2_last, s3_res, s3_last;
  logic signed [sstp_pkg::SCALED_W-1:0] sx, sy;
  logic signed [2*sstp_pkg::SCALED_W-1:0] pxx, pyy, pxy;

  logic                      skid_valid, skid_last;
  logic [sstp_pkg::SQ_W-1:0] skid_xx, skid_yy;
  logic signed [sstp_pkg::CROSS_W-1:0] skid_xy;
  logic                      out_take;

  // Configuration writes, accepted every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sstp_pkg::WIDTH_RESET;
      frame_height <= sstp_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sstp_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[sstp_pkg::WIDTH_REG_W-1:0];
        sstp_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp frame dimensions to the supported range
  always_comb begin
    fw_ext = CMPW'(frame_width);
    if (fw_ext < CMPW'(sstp_pkg::MIN_DIM)) begin
      w_use = CMPW'(sstp_pkg::MIN_DIM);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      w_use = CMPW'(MAX_WIDTH);
    end else begin
      w_use = fw_ext;
    end
    if (frame_height < HW'(sstp_pkg::MIN_DIM)) begin
      h_use = HW'(sstp_pkg::MIN_DIM);
    end else if (frame_height > HW'(sstp_pkg::HEIGHT_LIMIT)) begin
      h_use = HW'(sstp_pkg::HEIGHT_LIMIT);
    end else begin
      h_use = frame_height;
    end
  end

  // Handshake: the pipeline moves unless the skid stage is full
  assign adv       = !skid_valid;
  assign pix_stall = skid_valid;
  assign accept    = pix_valid && !pix_stall;

  // Position of the incoming pixel and its counter advance
  always_comb begin
    c_cur   = frame_start ? '0 : column_count;
    r_cur   = frame_start ? '0 : row_count;
    c_ext   = CMPW'(c_cur);
    r_ext   = HW'(r_cur);
    col_end = (c_ext + CMPW'(1)) >= w_use;
    row_end = (r_ext + HW'(1)) >= h_use;
    last    = col_end && row_end;
    produce = (c_ext >= CMPW'(2)) && (r_cur >= sstp_pkg::ROW_W'(2));
    if (col_end) begin
      column_count_next = '0;
      row_count_next    = row_end ? '0 : r_cur + sstp_pkg::ROW_W'(1);
    end else begin
      column_count_next = c_cur + CW'(1);
      row_count_next    = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Line stores and window
  assign win_ctl.adv  = adv;
  assign win_ctl.load = accept;

  sstp_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .ctl   (win_ctl),
    .pixel (pixel),
    .col   (c_cur),
    .win   (win)
  );

  // Result flags travel beside the window pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_res <= 1'b0;
      s2_res <= 1'b0;
      s3_res <= 1'b0;
    end else if (adv) begin
      s1_res <= accept && produce;
      s2_res <= s1_res;
      s3_res <= s2_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last <= last;
      s2_last <= s1_last;
      s3_last <= s2_last;
    end
  end

  // Gradients, rounding and clipping
  always_ff @(posedge clk) begin
    if (adv) begin
      sx <= sstp_pkg::scale_grad(sstp_pkg::grad_x(win));
      sy <= sstp_pkg::scale_grad(sstp_pkg::grad_y(win));
    end
  end

  // Products of the scaled gradients
  assign pxx = sx * sx;
  assign pyy = sy * sy;
  assign pxy = sx * sy;

  // Output register with skid stage behind it
  assign out_take = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (s3_res) begin
      if (res_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        res_valid <= 1'b1;
      end
    end else if (out_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        grad_xx    <= skid_xx;
        grad_yy    <= skid_yy;
        grad_xy    <= skid_xy;
        frame_last <= skid_last;
      end
    end else if (s3_res) begin
      if (res_valid && !out_take) begin
        skid_xx   <= pxx[sstp_pkg::SQ_W-1:0];
        skid_yy   <= pyy[sstp_pkg::SQ_W-1:0];
        skid_xy   <= pxy[sstp_pkg::CROSS_W-1:0];
        skid_last <= s3_last;
      end else begin
        grad_xx    <= pxx[sstp_pkg::SQ_W-1:0];
        grad_yy    <= pyy[sstp_pkg::SQ_W-1:0];
        grad_xy    <= pxy[sstp_pkg::CROSS_W-1:0];
        frame_last <= s3_last;
      end
    end
  end

endmodule

### hw/rtl/sstp_checker.sv
// ----------------------------------------------------------------------------
// sstp_port_checks
// Port-level checks for the Sobel structure tensor product block.
// ----------------------------------------------------------------------------
module sstp_port_checks (
  input logic                                clk,
  input logic                                rst,
  input logic                                pix_stall,
  input logic                                res_valid,
  input logic                                res_stall,
  input logic [sstp_pkg::SQ_W-1:0]           grad_xx,
  input logic [sstp_pkg::SQ_W-1:0]           grad_yy,
  input logic signed [sstp_pkg::CROSS_W-1:0] grad_xy,
  input logic                                frame_last
);

  // Input backpressure only while a result is held at the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (res_valid && $past(res_valid)))
    else $error("pixel stall without a held result");

  // Squares stay within the clipped gradient range
  a_square_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (grad_xx <= 14'd16129 && grad_yy <= 14'd16129))
    else $error("gradient square out of range");

  // A stalled result beat stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> res_valid)
    else $error("result beat dropped under stall");

  // A stalled result beat keeps its payload
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> ($stable(grad_xx) && $stable(grad_yy)
                                  && $stable(grad_xy) && $stable(frame_last)))
    else $error("result payload changed under stall");

endmodule

bind sobel_structure_tensor_products_top sstp_port_checks u_sstp_port_checks (.*);

### test/sstp_checker.sv
// ----------------------------------------------------------------------------
// sstp_checker
// Watches the pixel, result and configuration channels of the Sobel structure
// tensor block, predicts the gradient products of every accepted pixel beat
// and compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sstp_checker #(
  parameter int MAX_W = sstp_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  input  logic                                pix_stall,
  input  logic [sstp_pkg::PIX_W-1:0]          pixel,
  input  logic                                frame_start,
  input  logic                                res_valid,
  input  logic                                res_stall,
  input  logic [sstp_pkg::SQ_W-1:0]           grad_xx,
  input  logic [sstp_pkg::SQ_W-1:0]           grad_yy,
  input  logic signed [sstp_pkg::CROSS_W-1:0] grad_xy,
  input  logic                                frame_last,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [sstp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sstp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  error_count,
  output int                                  pending_results
);
  import sstp_pkg::*;

  typedef struct {
    logic [SQ_W-1:0]           xx;
    logic [SQ_W-1:0]           yy;
    logic signed [CROSS_W-1:0] xy;
    logic                      last;
  } tensor_t;

  tensor_t expected_products[$];
  tensor_t want;

  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [PIX_W-1:0]        upper_line [MAX_W];
  logic [PIX_W-1:0]        middle_line [MAX_W];
  logic [PIX_W-1:0]        win [9];
  int                      scan_col;
  int                      scan_row;
  int                      mismatches;

  initial begin
    mismatches = 0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
  end

  // Round (g+4)>>3 toward minus infinity, clip to signed 8 bits
  function automatic int scale_gradient(input int g);
    int s;
    s = ((g + 1028) >>> 3) - 128;
    if (s > 127) s = 127;
    if (s < -128) s = -128;
    return s;
  endfunction

  // Slide the window by one pixel beat and queue the products it yields
  function automatic void predict_products(input logic [PIX_W-1:0] p, input logic fs);
    int cols_used, rows_used, c, r, gx, gy, sx, sy;
    tensor_t t;
    cols_used = (width_reg < MIN_DIM) ? MIN_DIM : (width_reg > MAX_W) ? MAX_W : width_reg;
    rows_used = (height_reg < MIN_DIM) ? MIN_DIM :
                (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    if (fs) begin
      scan_col = 0;
      scan_row = 0;
    end
    c = scan_col % MAX_W;
    r = scan_row;

    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = upper_line[c];
    win[5] = middle_line[c];
    win[8] = p;
    upper_line[c] = middle_line[c];
    middle_line[c] = p;

    if (c >= 2 && r >= 2) begin
      gx = (int'(win[2]) - int'(win[0])) + 2 * (int'(win[5]) - int'(win[3]))
         + (int'(win[8]) - int'(win[6]));
      gy = (int'(win[6]) - int'(win[0])) + 2 * (int'(win[7]) - int'(win[1]))
         + (int'(win[8]) - int'(win[2]));
      sx = scale_gradient(gx);
      sy = scale_gradient(gy);
      t.xx = SQ_W'(sx * sx);
      t.yy = SQ_W'(sy * sy);
      t.xy = CROSS_W'(sx * sy);
      t.last = (c + 1 >= cols_used) && (r + 1 >= rows_used);
      expected_products.push_back(t);
    end

    // Wrap column, then row, at the limits in use
    if (c + 1 >= cols_used) begin
      scan_col = 0;
      scan_row = (r + 1 >= rows_used) ? 0 : r + 1;
    end else begin
      scan_col = c + 1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (win[i]) win[i] = '0;
      scan_col = 0;
      scan_row = 0;
      expected_products.delete();
    end else begin
      // Pixel beat sees the registers as they stood before this edge
      if (pix_valid && !pix_stall) predict_products(pixel, frame_start);
      // Register write beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH: width_reg = cfg_data[WIDTH_REG_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      // Result beat against oldest prediction
      if (res_valid && !res_stall) begin
        if (expected_products.size() == 0) begin
          $error("unexpected result beat: grad_xx %0d grad_yy %0d grad_xy %0d frame_last %0d",
                 grad_xx, grad_yy, grad_xy, frame_last);
          mismatches++;
        end else begin
          want = expected_products.pop_front();
          if (grad_xx !== want.xx) begin
            $error("grad_xx: expected %0d, got %0d", want.xx, grad_xx);
            mismatches++;
          end
          if (grad_yy !== want.yy) begin
            $error("grad_yy: expected %0d, got %0d", want.yy, grad_yy);
            mismatches++;
          end
          if (grad_xy !== want.xy) begin
            $error("grad_xy: expected %0d, got %0d", want.xy, grad_xy);
            mismatches++;
          end
          if (frame_last !== want.last) begin
            $error("frame_last: expected %0d, got %0d", want.last, frame_last);
            mismatches++;
          end
        end
      end
    end
    error_count <= mismatches;
    pending_results <= expected_products.size();
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives raster pixel frames and register writes into the Sobel structure
// tensor block under random idling and output stall, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
  import sstp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 640;
  localparam int PHASE_ITEMS  = 120;

  // Indexes past the defined registers; writes there change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  // Width 3, height 8: vertical extremes both ways, then horizontal clip
  localparam logic [PIX_W-1:0] EDGE_PATTERN [24] = '{
    8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,
    8'd255, 8'd255, 8'd255,
    8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd255,
    8'd0,   8'd0,   8'd255,
    8'd0,   8'd0,   8'd255
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      pix_valid = 1'b0;
  logic                      pix_stall;
  logic [PIX_W-1:0]          pixel = '0;
  logic                      frame_start = 1'b0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic [SQ_W-1:0]           grad_xx;
  logic [SQ_W-1:0]           grad_yy;
  logic signed [CROSS_W-1:0] grad_xy;
  logic                      frame_last;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  int error_count;
  int pending_results;
  int cycle_count = 0;
  int idle_odds = 0;
  bit calm = 1'b0;

  sobel_structure_tensor_products_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .pixel       (pixel),
    .frame_start (frame_start),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .grad_xx     (grad_xx),
    .grad_yy     (grad_yy),
    .grad_xy     (grad_xy),
    .frame_last  (frame_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  sstp_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .pix_valid       (pix_valid),
    .pix_stall       (pix_stall),
    .pixel           (pixel),
    .frame_start     (frame_start),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .grad_xx         (grad_xx),
    .grad_yy         (grad_yy),
    .grad_xy         (grad_xy),
    .frame_last      (frame_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output stall in random bursts; none once the run turns calm
  initial begin
    forever begin
      res_stall <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 120 : 25)) @(posedge clk);
      if (!calm) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Present one pixel beat and hold it until taken
  task automatic send_beat(input logic [PIX_W-1:0] p, input logic fs);
    pix_valid <= 1'b1;
    pixel <= p;
    frame_start <= fs;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, drain every outstanding result, then let the pipeline empty
  task automatic settle;
    pix_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int clamp_dim(input int v, input int hi);
    return (v < MIN_DIM) ? MIN_DIM : (v > hi) ? hi : v;
  endfunction

  // Stream raster frames; frame_start leads the first frame when lead is set,
  // is sometimes left out at a wrap, and noisy runs drop a stray frame_start mid-frame.
  // Valid stays up after the last beat; settle drops it.
  task automatic stream_pixels(input int cols, input int rows, input int total,
                               input bit binary, input bit lead, input bit noisy);
    int col_at, row_at;
    logic fs;
    logic [PIX_W-1:0] p;
    col_at = 0;
    row_at = 0;
    for (int n = 0; n < total; n++) begin
      if (n == 0) begin
        fs = lead;
      end else if (col_at == 0 && row_at == 0) begin
        fs = ($urandom_range(0, 3) != 0);
      end else if (noisy && $urandom_range(0, 149) == 0) begin
        fs = 1'b1;
        col_at = 0;
        row_at = 0;
      end else begin
        fs = 1'b0;
      end
      if (binary && $urandom_range(0, 7) != 0) p = {PIX_W{1'($urandom_range(0, 1))}};
      else p = PIX_W'($urandom_range(0, 255));
      send_beat(p, fs);

      // Track position for frame boundaries
      if (col_at + 1 >= cols) begin
        col_at = 0;
        row_at = (row_at + 1 >= rows) ? 0 : row_at + 1;
      end else begin
        col_at++;
      end

      // Sender gap burst
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        pix_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  endtask

  initial begin
    int random_items, phase, w_raw, h_raw, wf, hf, total;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a short run into the first row, without frame_start
    idle_odds = 6;
    stream_pixels(640, 480, 40, 1'b0, 1'b0, 1'b0);

    // Edge pattern frame
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd8);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    idle_odds = 3;
    for (int i = 0; i < 24; i++) send_beat(EDGE_PATTERN[i], i == 0);

    // Random phases of small frames
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin w_raw = 0; h_raw = 0; end
        1: begin w_raw = 2; h_raw = 1; end
        2: begin w_raw = 1; h_raw = 2; end
        default: begin
          case ($urandom_range(0, 9))
            0: w_raw = $urandom_range(0, 2);
            1, 2: w_raw = $urandom_range(11, 48);
            default: w_raw = $urandom_range(3, 10);
          endcase
          case ($urandom_range(0, 9))
            0: h_raw = $urandom_range(0, 2);
            1: h_raw = $urandom_range(7, 12);
            default: h_raw = $urandom_range(3, 6);
          endcase
        end
      endcase
      settle();
      write_reg(REG_FRAME_WIDTH, {1'($urandom_range(0, 1)), 12'(w_raw)});
      write_reg(REG_FRAME_HEIGHT, 13'(h_raw));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));

      wf = clamp_dim(w_raw, MAX_WIDTH_DEF);
      hf = clamp_dim(h_raw, HEIGHT_LIMIT);
      total = $urandom_range(1, 3) * wf * hf;
      if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
      if (total > PHASE_ITEMS) total = PHASE_ITEMS;
      case ($urandom_range(0, 3))
        0: idle_odds = 0;
        1: idle_odds = 2;
        default: idle_odds = 8;
      endcase
      stream_pixels(wf, hf, total, $urandom_range(0, 2) == 0, 1'b1, 1'b1);
      random_items += total;
      phase++;
    end

    // Calm tail: two full frames back to back, wrapping between them
    calm = 1'b1;
    idle_odds = 0;
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd6);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    stream_pixels(6, 4, 48, 1'b0, 1'b1, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
